// ===== hw/rtl/pn2d_pkg.sv =====
// ----------------------------------------------------------------------------
// pn2d_pkg
// Shared types and fixed constants of the 2D gradient noise pipeline.
// ----------------------------------------------------------------------------
package pn2d_pkg;

  localparam int COORD_W     = 32;
  localparam int CELL_W      = 8;
  localparam int TABLE_DEPTH = 512;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int VAL_W       = 8;
  localparam int NOISE_W     = 18;
  localparam int NOISE_MAX   = 131071;
  localparam int NOISE_MIN   = -131072;

  // fade polynomial coefficients 6t^5 - 15t^4 + 10t^3
  localparam int FADE_A = 6;
  localparam int FADE_B = 15;
  localparam int FADE_C = 10;

  // diagonal gradient picked by hash bits 1:0
  typedef enum logic [1:0] {
    GRAD_PP,
    GRAD_NP,
    GRAD_PN,
    GRAD_NN
  } grad_e;

endpackage

// ===== hw/rtl/pn2d_perm_ram.sv =====
// ----------------------------------------------------------------------------
// pn2d_perm_ram
// One copy of the permutation table: one write port, two registered read
// ports that hold their data while the read enable is low.
// ----------------------------------------------------------------------------
module pn2d_perm_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [pn2d_pkg::IDX_W-1:0] waddr_i,
  input  logic [pn2d_pkg::VAL_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [pn2d_pkg::IDX_W-1:0] raddr_a_i,
  input  logic [pn2d_pkg::IDX_W-1:0] raddr_b_i,
  output logic [pn2d_pkg::VAL_W-1:0] rdata_a_o,
  output logic [pn2d_pkg::VAL_W-1:0] rdata_b_o
);
  import pn2d_pkg::*;

  logic [VAL_W-1:0] mem_q [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ===== hw/rtl/perlin_noise_2d_fixed.sv =====
// ----------------------------------------------------------------------------
// perlin_noise_2d_fixed
// Pipelined 2D gradient noise on signed fixed-point coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per handshake.
//   cmd_i = 1 writes entry_value_i into table entry entry_index_i and gives
//   no result; cmd_i = 0 evaluates noise at (x_coord_i, y_coord_i) and gives
//   exactly one noise_value_o on the output channel (out_valid_o /
//   out_stall_i). Results leave in the order the items came in.
//   Throughput: one item per cycle while in_stall_o is low. The table is held
//   in three copies of two read ports each, so the two row reads and the four
//   corner reads of an item happen in two stages without sharing a port.
//   Pipeline: ten register stages from acceptance to result (two table reads,
//   four fade multiplies, lerp multiplies, output).
//   Stall: a stalled result holds in the output register; earlier stages
//   keep filling bubbles, and in_stall_o rises only when all ten stages
//   hold an item. Write items leave the pipeline after the first stage.
//   Reset clears all stage valid bits. Table contents are undefined until
//   written; load every entry that evaluations will touch before use.
// ----------------------------------------------------------------------------
module perlin_noise_2d_fixed #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic signed [pn2d_pkg::COORD_W-1:0] x_coord_i,
  input  logic signed [pn2d_pkg::COORD_W-1:0] y_coord_i,
  input  logic [pn2d_pkg::IDX_W-1:0]          entry_index_i,
  input  logic [pn2d_pkg::VAL_W-1:0]          entry_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [pn2d_pkg::NOISE_W-1:0] noise_value_o
);
  import pn2d_pkg::*;

  localparam int F    = FRACTION_BITS;
  localparam int W    = F + 6;
  localparam int PW   = 2 * W;
  localparam int NSTG = 10;

  localparam logic signed [W-1:0]  ONE_FX   = W'(2 ** F);
  localparam logic signed [W-1:0]  FADE_B_S = W'(FADE_B * (2 ** F));
  localparam logic signed [W-1:0]  FADE_C_S = W'(FADE_C * (2 ** F));
  localparam logic signed [PW:0]   RND_HALF = (PW + 1)'(2 ** (F - 1));

  function automatic logic signed [W-1:0] fext(input logic [F-1:0] f);
    fext = $signed(W'(f));
  endfunction

  function automatic logic signed [PW-1:0] mul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    mul = PW'(a) * PW'(b);
  endfunction

  // round to nearest, ties upward, then drop the fraction
  function automatic logic signed [W-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW:0] t;
    t   = (PW + 1)'(p) + RND_HALF;
    rnd = W'(t >>> F);
  endfunction

  function automatic logic signed [W-1:0] grad(input logic [VAL_W-1:0] h,
                                               input logic signed [W-1:0] dx,
                                               input logic signed [W-1:0] dy);
    case (grad_e'(h[1:0]))
      GRAD_PP: grad = dx + dy;
      GRAD_NP: grad = dy - dx;
      GRAD_PN: grad = dx - dy;
      GRAD_NN: grad = -dx - dy;
      default: grad = dx + dy;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stage control
  // --------------------------------------------------------------------------
  logic [NSTG:1] v_q;
  logic [NSTG:1] en;
  logic          in_accept;

  always_comb begin
    en[NSTG] = !v_q[NSTG] || !out_stall_i;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[1];
  assign in_accept   = in_valid_i && en[1];
  assign out_valid_o = v_q[NSTG];

  logic cmd1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      // drop write items once the last table copy has taken them
      if (en[2]) v_q[2] <= v_q[1] && !cmd1_q;
      for (int k = 3; k <= NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Table copies
  // --------------------------------------------------------------------------
  logic [CELL_W-1:0] gx_in;
  logic [IDX_W-1:0]  ra_addr0, ra_addr1;
  logic [VAL_W-1:0]  px0, px1;
  logic [CELL_W-1:0] gy1_q;
  logic [IDX_W-1:0]  idx1_q;
  logic [VAL_W-1:0]  val1_q;
  logic [IDX_W-1:0]  rb_addr0, rb_addr1, rc_addr0, rc_addr1;
  logic [VAL_W-1:0]  h1, h2, h3, h4;
  logic              wr_late;

  assign gx_in    = x_coord_i[F+CELL_W-1:F];
  assign ra_addr0 = IDX_W'(gx_in);
  assign ra_addr1 = IDX_W'(gx_in) + IDX_W'(1);

  pn2d_perm_ram u_ram_row (
    .clk_i     (clk_i),
    .we_i      (in_accept && cmd_i),
    .waddr_i   (entry_index_i),
    .wdata_i   (entry_value_i),
    .re_i      (en[1]),
    .raddr_a_i (ra_addr0),
    .raddr_b_i (ra_addr1),
    .rdata_a_o (px0),
    .rdata_b_o (px1)
  );

  assign wr_late  = en[2] && v_q[1] && cmd1_q;
  assign rb_addr0 = IDX_W'(px0) + IDX_W'(gy1_q);
  assign rb_addr1 = IDX_W'(px0) + IDX_W'(gy1_q) + IDX_W'(1);
  assign rc_addr0 = IDX_W'(px1) + IDX_W'(gy1_q);
  assign rc_addr1 = IDX_W'(px1) + IDX_W'(gy1_q) + IDX_W'(1);

  pn2d_perm_ram u_ram_col0 (
    .clk_i     (clk_i),
    .we_i      (wr_late),
    .waddr_i   (idx1_q),
    .wdata_i   (val1_q),
    .re_i      (en[2]),
    .raddr_a_i (rb_addr0),
    .raddr_b_i (rb_addr1),
    .rdata_a_o (h1),
    .rdata_b_o (h3)
  );

  pn2d_perm_ram u_ram_col1 (
    .clk_i     (clk_i),
    .we_i      (wr_late),
    .waddr_i   (idx1_q),
    .wdata_i   (val1_q),
    .re_i      (en[2]),
    .raddr_a_i (rc_addr0),
    .raddr_b_i (rc_addr1),
    .rdata_a_o (h2),
    .rdata_b_o (h4)
  );

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic [F-1:0]           fx_q [1:4];
  logic [F-1:0]           fy_q [1:4];
  logic signed [PW-1:0]   p1x_q, p1y_q, p2x_q, p2y_q, p3x_q, p3y_q, p4x_q, p4y_q;
  logic signed [W-1:0]    g1_q [3:7];
  logic signed [W-1:0]    g3_q [3:7];
  logic signed [W-1:0]    g2_q [3:6];
  logic signed [W-1:0]    g4_q [3:6];
  logic signed [W-1:0]    u6_q, v6_q, v7_q, v8_q;
  logic signed [PW-1:0]   pa7_q, pb7_q, pc9_q;
  logic signed [W-1:0]    a8_q, b8_q, a9_q;
  logic signed [NOISE_W-1:0] noise_q;

  logic signed [W-1:0]    dx0, dx1, dy0, dy1;
  logic signed [W-1:0]    c10;
  logic signed [31:0]     c32;
  logic signed [NOISE_W-1:0] noise_d;

  assign dx0 = fext(fx_q[2]);
  assign dx1 = dx0 - ONE_FX;
  assign dy0 = fext(fy_q[2]);
  assign dy1 = dy0 - ONE_FX;

  assign c10 = a9_q + rnd(pc9_q);
  assign c32 = 32'(c10);

  always_comb begin
    if (c32 > NOISE_MAX) begin
      noise_d = NOISE_W'(NOISE_MAX);
    end else if (c32 < NOISE_MIN) begin
      noise_d = NOISE_W'(NOISE_MIN);
    end else begin
      noise_d = NOISE_W'(c32);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      cmd1_q   <= cmd_i;
      gy1_q    <= y_coord_i[F+CELL_W-1:F];
      fx_q[1]  <= x_coord_i[F-1:0];
      fy_q[1]  <= y_coord_i[F-1:0];
      idx1_q   <= entry_index_i;
      val1_q   <= entry_value_i;
    end
    if (en[2]) begin
      fx_q[2] <= fx_q[1];
      fy_q[2] <= fy_q[1];
      p1x_q   <= mul(fext(fx_q[1]), W'(FADE_A) * fext(fx_q[1]) - FADE_B_S);
      p1y_q   <= mul(fext(fy_q[1]), W'(FADE_A) * fext(fy_q[1]) - FADE_B_S);
    end
    if (en[3]) begin
      fx_q[3] <= fx_q[2];
      fy_q[3] <= fy_q[2];
      p2x_q   <= mul(fext(fx_q[2]), rnd(p1x_q) + FADE_C_S);
      p2y_q   <= mul(fext(fy_q[2]), rnd(p1y_q) + FADE_C_S);
      g1_q[3] <= grad(h1, dx0, dy0);
      g2_q[3] <= grad(h2, dx1, dy0);
      g3_q[3] <= grad(h3, dx0, dy1);
      g4_q[3] <= grad(h4, dx1, dy1);
    end
    if (en[4]) begin
      fx_q[4] <= fx_q[3];
      fy_q[4] <= fy_q[3];
      p3x_q   <= mul(fext(fx_q[3]), rnd(p2x_q));
      p3y_q   <= mul(fext(fy_q[3]), rnd(p2y_q));
    end
    if (en[5]) begin
      p4x_q <= mul(fext(fx_q[4]), rnd(p3x_q));
      p4y_q <= mul(fext(fy_q[4]), rnd(p3y_q));
    end
    if (en[6]) begin
      u6_q <= rnd(p4x_q);
      v6_q <= rnd(p4y_q);
    end
    // carry the corner gradients down to the lerp stages
    for (int k = 4; k <= 6; k++) begin
      if (en[k]) begin
        g1_q[k] <= g1_q[k-1];
        g2_q[k] <= g2_q[k-1];
        g3_q[k] <= g3_q[k-1];
        g4_q[k] <= g4_q[k-1];
      end
    end
    if (en[7]) begin
      g1_q[7] <= g1_q[6];
      g3_q[7] <= g3_q[6];
      v7_q    <= v6_q;
      pa7_q   <= mul(g2_q[6] - g1_q[6], u6_q);
      pb7_q   <= mul(g4_q[6] - g3_q[6], u6_q);
    end
    if (en[8]) begin
      a8_q <= g1_q[7] + rnd(pa7_q);
      b8_q <= g3_q[7] + rnd(pb7_q);
      v8_q <= v7_q;
    end
    if (en[9]) begin
      a9_q  <= a8_q;
      pc9_q <= mul(b8_q - a8_q, v8_q);
    end
    if (en[10]) begin
      noise_q <= noise_d;
    end
  end

  assign noise_value_o = noise_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q) && out_stall_i)
    else $error("input stalled while the pipeline has a free stage");

  a_write_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] && cmd1_q && en[2] |=> !v_q[2])
    else $error("write item passed beyond the table stages");

  a_fade_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[6] |-> (u6_q >= 0) && (u6_q <= ONE_FX) && (v6_q >= 0) && (v6_q <= ONE_FX))
    else $error("fade weight outside the unit interval");

endmodule
